>>> src/bba_pkg.sv
`timescale 1ns / 1ps
package bba_pkg;

  localparam int MAX_LEAVES_DEF      = 1024;
  localparam int MIN_BLOCK_BYTES_DEF = 1024;
  localparam int LEVEL_COUNT_DEF     = 11;
  localparam int LEAF_COUNT_RESET    = 1024;
  localparam int TAG_NONE            = 15;
  localparam int WORD_BITS           = 32;
  localparam int WORD_SHIFT          = 5;

  typedef enum logic [1:0] {
    K_REBUILD = 2'd0,
    K_ALLOC   = 2'd1,
    K_FREE    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_BLOCK  = 3'd3,
    ST_BAD_ADDR  = 3'd4,
    ST_NULL      = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_CLR,
    S_RB_CHK,
    S_RB_RD,
    S_RB_WR,
    S_A_LVL,
    S_A_SET,
    S_A_RD,
    S_A_CHK,
    S_A_SPLIT,
    S_A_SPRD,
    S_A_SPWR,
    S_F_CHK,
    S_F_TAG,
    S_F_LOOP,
    S_F_RD,
    S_F_WR,
    S_F_END,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_CLR_START,
    DP_CLR_STEP,
    DP_RB_SET,
    DP_RB_NEXT,
    DP_RB_WR,
    DP_A_LEVEL,
    DP_A_SCAN_SET,
    DP_A_CHK,
    DP_A_SPLIT,
    DP_A_SP_WR,
    DP_A_TAG,
    DP_F_TAG,
    DP_F_LOOP,
    DP_F_WR,
    DP_F_OK,
    DP_RESULT,
    DP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  i_lt_l;
    logic  rb_odd;
    logic  size_bad;
    logic  cap_bad;
    logic  scan_found;
    logic  scan_last;
    logic  split_more;
    logic  f_null;
    logic  f_bad;
    logic  tag_none;
    logic  merge;
    logic  clr_last;
    logic  out_free;
  } dp_stat_t;

endpackage

>>> src/bba_ram.sv
`timescale 1ns / 1ps
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/bba_datapath.sv
`timescale 1ns / 1ps
module bba_datapath #(
  parameter int MAX_LEAVES      = bba_pkg::MAX_LEAVES_DEF,
  parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF,
  parameter int LEVEL_COUNT     = bba_pkg::LEVEL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bba_pkg::dp_cmd_t  cmd,
  output bba_pkg::dp_stat_t stat,
  input  logic [1:0]        in_kind,
  input  logic [47:0]       in_request_size,
  input  logic [47:0]       in_release_address,
  input  logic [10:0]       leaf_count,
  input  logic [47:0]       pool_base,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [47:0]       out_granted_address,
  output logic [3:0]        out_block_level
);

  localparam int LW      = $clog2(MAX_LEAVES);
  localparam int NW      = LW + 1;
  localparam int IW      = $clog2(LEVEL_COUNT + 1);
  localparam int TW      = (IW > 4) ? IW : 4;
  localparam int BW      = (LW + 1 > 6) ? LW + 1 : 6;
  localparam int WSH     = bba_pkg::WORD_SHIFT;
  localparam int WAW     = BW - WSH;
  localparam int WORDS   = 1 << WAW;
  localparam int SH      = $clog2(MIN_BLOCK_BYTES);
  localparam int TWO_M   = 2 * MAX_LEAVES;
  localparam int N_RESET = (bba_pkg::LEAF_COUNT_RESET > MAX_LEAVES) ? MAX_LEAVES
                                                                   : bba_pkg::LEAF_COUNT_RESET;

  function automatic logic [BW-1:0] base_of(input logic [IW-1:0] lv);
    logic [31:0] t;
    t = 32'(TWO_M) - (32'(TWO_M) >> lv);
    return BW'(t);
  endfunction

  bba_pkg::kind_t   kind_r, kind_nxt;
  logic [47:0]      size_r, size_nxt;
  logic [47:0]      addr_r, addr_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [NW-1:0]    used_r, used_nxt;
  logic [IW-1:0]    i_r, i_nxt;
  logic [IW-1:0]    lvl_r, lvl_nxt;
  logic [LW-1:0]    off_r, off_nxt;
  logic [BW-1:0]    fa_r, fa_nxt;
  logic [WAW-1:0]   wa_r, wa_nxt;
  logic [WAW-1:0]   hiw_r, hiw_nxt;
  logic [LW-1:0]    ctr_r, ctr_nxt;
  bba_pkg::status_t res_status_r, res_status_nxt;
  logic [47:0]      res_addr_r, res_addr_nxt;
  logic [3:0]       res_level_r, res_level_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  logic [47:0]      out_addr_r, out_addr_nxt;
  logic [3:0]       out_level_r, out_level_nxt;

  logic [NW-1:0]    n_c;
  logic [IW-1:0]    lt_c;
  logic [NW-1:0]    c_i;
  logic [BW-1:0]    base_i;
  logic [BW-1:0]    base_dn;
  logic [BW:0]      hi_i;
  logic [BW-1:0]    hi_m1;
  logic [IW-1:0]    lvl_c;
  logic             lvl_ok;
  logic             cap_bad;
  logic [31:0]      hit;
  logic             found;
  logic [4:0]       b_c;
  logic [BW-1:0]    flat_c;
  logic [LW-1:0]    k_c;
  logic [47:0]      rel_c;
  logic [47:0]      leaf64_c;
  logic [LW-1:0]    leaf_c;
  logic [LW-1:0]    leaf_a;
  logic [47:0]      granted_c;
  logic [NW-1:0]    used_dec;
  logic [BW-1:0]    fa_rb;
  logic [BW-1:0]    fa_sp;
  logic [BW-1:0]    fa_fr;
  logic             merge;
  logic [4:0]       pos;
  logic [4:0]       bud_pos;

  logic                 bm_we;
  logic [WAW-1:0]       bm_waddr;
  logic [31:0]          bm_wdata;
  logic [31:0]          bm_rd;
  logic                 tag_we;
  logic [LW-1:0]        tag_waddr;
  logic [TW-1:0]        tag_wdata;
  logic [TW-1:0]        tag_rd;

  bba_ram #(.WIDTH(bba_pkg::WORD_BITS), .DEPTH(WORDS)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (wa_r),
    .rdata (bm_rd)
  );

  bba_ram #(.WIDTH(TW), .DEPTH(MAX_LEAVES)) u_tag (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (leaf_c),
    .rdata (tag_rd)
  );

  always_comb begin
    logic [31:0] lc32;
    lc32 = 32'(leaf_count);
    n_c  = (lc32 > 32'(MAX_LEAVES)) ? NW'(MAX_LEAVES) : NW'(lc32);
  end

  always_comb begin
    lt_c = '0;
    for (int j = 0; j < LEVEL_COUNT; j++) begin
      if ((32'(n_r) >> j) != 32'd0) begin
        lt_c = IW'(j + 1);
      end
    end
  end

  assign c_i     = n_r >> i_r;
  assign base_i  = base_of(i_r);
  assign base_dn = base_of(i_r - IW'(1));
  assign hi_i    = {1'b0, base_i} + (BW+1)'(c_i);
  assign hi_m1   = BW'(hi_i - (BW+1)'(1));

  always_comb begin
    lvl_c  = '0;
    lvl_ok = 1'b0;
    for (int j = LEVEL_COUNT - 1; j >= 0; j--) begin
      if ((j < 32'(lt_c)) && (size_r <= (48'(MIN_BLOCK_BYTES) << j))) begin
        lvl_c  = IW'(j);
        lvl_ok = 1'b1;
      end
    end
  end

  assign cap_bad = ((NW+1)'(used_r) + ((NW+1)'(1) << lvl_c)) > (NW+1)'(n_r);

  always_comb begin
    logic [BW:0] fl;
    found = 1'b0;
    b_c   = '0;
    for (int b = 0; b < 32; b++) begin
      fl = {1'b0, wa_r, 5'(b)};
      hit[b] = bm_rd[b] && (fl >= {1'b0, base_i}) && (fl < hi_i);
    end
    for (int b = 31; b >= 0; b--) begin
      if (hit[b]) begin
        found = 1'b1;
        b_c   = 5'(b);
      end
    end
  end

  assign flat_c = {wa_r, b_c};
  assign k_c    = LW'(flat_c - base_i);

  assign rel_c    = addr_r - pool_base;
  assign leaf64_c = rel_c >> SH;
  assign leaf_c   = leaf64_c[LW-1:0];
  assign leaf_a   = off_r << lvl_r;
  assign granted_c = pool_base + (48'(leaf_a) << SH);

  always_comb begin
    logic [31:0] sz;
    logic [31:0] u32;
    sz  = 32'd1 << tag_rd;
    u32 = 32'(used_r);
    used_dec = (u32 >= sz) ? NW'(u32 - sz) : '0;
  end

  assign fa_rb   = BW'(base_i + BW'(c_i) - BW'(1));
  assign fa_sp   = base_dn + (BW'(off_r) << 1);
  assign fa_fr   = base_i + BW'(off_r);
  assign pos     = fa_r[4:0];
  assign bud_pos = fa_r[4:0] ^ 5'd1;
  assign merge   = (NW'(off_r ^ LW'(1)) < c_i) && bm_rd[bud_pos];

  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = wa_r;
    bm_wdata  = bm_rd;
    tag_we    = 1'b0;
    tag_waddr = leaf_c;
    tag_wdata = TW'(bba_pkg::TAG_NONE);
    unique case (cmd.op)
      bba_pkg::DP_CLR_STEP: begin
        bm_we     = (32'(ctr_r) < 32'(WORDS));
        bm_waddr  = WAW'(ctr_r);
        bm_wdata  = '0;
        tag_we    = 1'b1;
        tag_waddr = ctr_r;
      end
      bba_pkg::DP_RB_WR: begin
        bm_we    = 1'b1;
        bm_wdata = bm_rd | (32'd1 << pos);
      end
      bba_pkg::DP_A_CHK: begin
        bm_we    = found;
        bm_wdata = bm_rd & ~(32'd1 << b_c);
      end
      bba_pkg::DP_A_SP_WR: begin
        bm_we    = 1'b1;
        bm_wdata = (bm_rd & ~(32'd1 << pos)) | (32'd1 << bud_pos);
      end
      bba_pkg::DP_F_WR: begin
        bm_we    = 1'b1;
        bm_wdata = merge ? (bm_rd & ~(32'd1 << pos) & ~(32'd1 << bud_pos))
                         : (bm_rd | (32'd1 << pos));
      end
      bba_pkg::DP_A_TAG: begin
        tag_we    = 1'b1;
        tag_waddr = leaf_a;
        tag_wdata = TW'(lvl_r);
      end
      bba_pkg::DP_F_TAG: begin
        tag_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    kind_nxt       = kind_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    n_nxt          = n_r;
    used_nxt       = used_r;
    i_nxt          = i_r;
    lvl_nxt        = lvl_r;
    off_nxt        = off_r;
    fa_nxt         = fa_r;
    wa_nxt         = wa_r;
    hiw_nxt        = hiw_r;
    ctr_nxt        = ctr_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_level_nxt  = res_level_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_level_nxt  = out_level_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (cmd.op)
      bba_pkg::DP_ACCEPT: begin
        kind_nxt = bba_pkg::kind_t'(in_kind);
        size_nxt = in_request_size;
        addr_nxt = in_release_address;
        n_nxt    = n_c;
      end
      bba_pkg::DP_CLR_START: begin
        ctr_nxt  = '0;
        used_nxt = '0;
        i_nxt    = '0;
      end
      bba_pkg::DP_CLR_STEP: ctr_nxt = ctr_r + LW'(1);
      bba_pkg::DP_RB_SET: begin
        fa_nxt = fa_rb;
        wa_nxt = fa_rb[BW-1:WSH];
      end
      bba_pkg::DP_RB_NEXT: i_nxt = i_r + IW'(1);
      bba_pkg::DP_RB_WR: i_nxt = i_r + IW'(1);
      bba_pkg::DP_A_LEVEL: begin
        lvl_nxt = lvl_c;
        i_nxt   = lvl_c;
      end
      bba_pkg::DP_A_SCAN_SET: begin
        wa_nxt  = base_i[BW-1:WSH];
        hiw_nxt = hi_m1[BW-1:WSH];
      end
      bba_pkg::DP_A_CHK: begin
        if (found) begin
          off_nxt = k_c;
        end else if (wa_r == hiw_r) begin
          i_nxt = i_r + IW'(1);
        end else begin
          wa_nxt = wa_r + WAW'(1);
        end
      end
      bba_pkg::DP_A_SPLIT: begin
        i_nxt   = i_r - IW'(1);
        off_nxt = off_r << 1;
        fa_nxt  = fa_sp;
        wa_nxt  = fa_sp[BW-1:WSH];
      end
      bba_pkg::DP_A_TAG: begin
        used_nxt       = used_r + (NW'(1) << lvl_r);
        res_status_nxt = bba_pkg::ST_OK;
        res_addr_nxt   = granted_c;
        res_level_nxt  = 4'(lvl_r);
      end
      bba_pkg::DP_F_TAG: begin
        lvl_nxt  = IW'(tag_rd);
        i_nxt    = IW'(tag_rd);
        off_nxt  = leaf_c >> tag_rd;
        used_nxt = used_dec;
      end
      bba_pkg::DP_F_LOOP: begin
        fa_nxt = fa_fr;
        wa_nxt = fa_fr[BW-1:WSH];
      end
      bba_pkg::DP_F_WR: begin
        if (merge) begin
          off_nxt = off_r >> 1;
          i_nxt   = i_r + IW'(1);
        end
      end
      bba_pkg::DP_F_OK: begin
        res_status_nxt = bba_pkg::ST_OK;
        res_addr_nxt   = '0;
        res_level_nxt  = 4'(lvl_r);
      end
      bba_pkg::DP_RESULT: begin
        res_status_nxt = cmd.code;
        res_addr_nxt   = '0;
        res_level_nxt  = '0;
      end
      bba_pkg::DP_PUSH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status_r;
        out_addr_nxt   = res_addr_r;
        out_level_nxt  = res_level_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= NW'(N_RESET);
      used_r      <= '0;
      i_r         <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      used_r      <= used_nxt;
      i_r         <= i_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    lvl_r        <= lvl_nxt;
    off_r        <= off_nxt;
    fa_r         <= fa_nxt;
    wa_r         <= wa_nxt;
    hiw_r        <= hiw_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_level_r  <= res_level_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_level_r  <= out_level_nxt;
  end

  assign stat.kind       = kind_r;
  assign stat.i_lt_l     = i_r < lt_c;
  assign stat.rb_odd     = c_i[0];
  assign stat.size_bad   = !lvl_ok;
  assign stat.cap_bad    = cap_bad;
  assign stat.scan_found = found;
  assign stat.scan_last  = wa_r == hiw_r;
  assign stat.split_more = i_r > lvl_r;
  assign stat.f_null     = addr_r == 48'd0;
  assign stat.f_bad      = (addr_r < pool_base) || (leaf64_c >= 48'(n_r));
  assign stat.tag_none   = tag_rd == TW'(bba_pkg::TAG_NONE);
  assign stat.merge      = merge;
  assign stat.clr_last   = ctr_r == LW'(MAX_LEAVES - 1);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;
  assign out_block_level     = out_level_r;

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bba_pkg::DP_PUSH) |-> (!out_valid_r || out_ready))
    else $error("result pushed over an untaken result");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bba_pkg::DP_A_TAG) |=> (used_r <= n_r))
    else $error("used leaves exceed pool after allocate");
`endif

endmodule

>>> src/bba_controller.sv
`timescale 1ns / 1ps
module bba_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t  cmd
);

  bba_pkg::ctrl_state_t state_r, state_nxt;
  logic                 from_item_r, from_item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_CLR;
      from_item_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_item_r <= from_item_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    from_item_nxt = from_item_r;
    in_ready      = 1'b0;
    cmd.op        = bba_pkg::DP_NOP;
    cmd.code      = bba_pkg::ST_OK;
    unique case (state_r)
      bba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = bba_pkg::DP_ACCEPT;
          state_nxt = bba_pkg::S_DECODE;
        end
      end
      bba_pkg::S_DECODE: begin
        case (stat.kind)
          bba_pkg::K_REBUILD: begin
            cmd.op        = bba_pkg::DP_CLR_START;
            from_item_nxt = 1'b1;
            state_nxt     = bba_pkg::S_CLR;
          end
          bba_pkg::K_ALLOC: state_nxt = bba_pkg::S_A_LVL;
          bba_pkg::K_FREE:  state_nxt = bba_pkg::S_F_CHK;
          default: begin
            cmd.op    = bba_pkg::DP_RESULT;
            state_nxt = bba_pkg::S_DONE;
          end
        endcase
      end
      bba_pkg::S_CLR: begin
        cmd.op = bba_pkg::DP_CLR_STEP;
        if (stat.clr_last) begin
          state_nxt = bba_pkg::S_RB_CHK;
        end
      end
      bba_pkg::S_RB_CHK: begin
        if (!stat.i_lt_l) begin
          if (from_item_r) begin
            cmd.op        = bba_pkg::DP_RESULT;
            from_item_nxt = 1'b0;
            state_nxt     = bba_pkg::S_DONE;
          end else begin
            state_nxt = bba_pkg::S_IDLE;
          end
        end else if (stat.rb_odd) begin
          cmd.op    = bba_pkg::DP_RB_SET;
          state_nxt = bba_pkg::S_RB_RD;
        end else begin
          cmd.op = bba_pkg::DP_RB_NEXT;
        end
      end
      bba_pkg::S_RB_RD: state_nxt = bba_pkg::S_RB_WR;
      bba_pkg::S_RB_WR: begin
        cmd.op    = bba_pkg::DP_RB_WR;
        state_nxt = bba_pkg::S_RB_CHK;
      end
      bba_pkg::S_A_LVL: begin
        if (stat.size_bad) begin
          cmd.op    = bba_pkg::DP_RESULT;
          cmd.code  = bba_pkg::ST_TOO_LARGE;
          state_nxt = bba_pkg::S_DONE;
        end else if (stat.cap_bad) begin
          cmd.op    = bba_pkg::DP_RESULT;
          cmd.code  = bba_pkg::ST_FULL;
          state_nxt = bba_pkg::S_DONE;
        end else begin
          cmd.op    = bba_pkg::DP_A_LEVEL;
          state_nxt = bba_pkg::S_A_SET;
        end
      end
      bba_pkg::S_A_SET: begin
        if (!stat.i_lt_l) begin
          cmd.op    = bba_pkg::DP_RESULT;
          cmd.code  = bba_pkg::ST_NO_BLOCK;
          state_nxt = bba_pkg::S_DONE;
        end else begin
          cmd.op    = bba_pkg::DP_A_SCAN_SET;
          state_nxt = bba_pkg::S_A_RD;
        end
      end
      bba_pkg::S_A_RD: state_nxt = bba_pkg::S_A_CHK;
      bba_pkg::S_A_CHK: begin
        cmd.op = bba_pkg::DP_A_CHK;
        if (stat.scan_found) begin
          state_nxt = bba_pkg::S_A_SPLIT;
        end else if (stat.scan_last) begin
          state_nxt = bba_pkg::S_A_SET;
        end else begin
          state_nxt = bba_pkg::S_A_RD;
        end
      end
      bba_pkg::S_A_SPLIT: begin
        if (stat.split_more) begin
          cmd.op    = bba_pkg::DP_A_SPLIT;
          state_nxt = bba_pkg::S_A_SPRD;
        end else begin
          cmd.op    = bba_pkg::DP_A_TAG;
          state_nxt = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_A_SPRD: state_nxt = bba_pkg::S_A_SPWR;
      bba_pkg::S_A_SPWR: begin
        cmd.op    = bba_pkg::DP_A_SP_WR;
        state_nxt = bba_pkg::S_A_SPLIT;
      end
      bba_pkg::S_F_CHK: begin
        if (stat.f_null) begin
          cmd.op    = bba_pkg::DP_RESULT;
          cmd.code  = bba_pkg::ST_NULL;
          state_nxt = bba_pkg::S_DONE;
        end else if (stat.f_bad) begin
          cmd.op    = bba_pkg::DP_RESULT;
          cmd.code  = bba_pkg::ST_BAD_ADDR;
          state_nxt = bba_pkg::S_DONE;
        end else begin
          state_nxt = bba_pkg::S_F_TAG;
        end
      end
      bba_pkg::S_F_TAG: begin
        if (stat.tag_none) begin
          cmd.op    = bba_pkg::DP_RESULT;
          cmd.code  = bba_pkg::ST_BAD_ADDR;
          state_nxt = bba_pkg::S_DONE;
        end else begin
          cmd.op    = bba_pkg::DP_F_TAG;
          state_nxt = bba_pkg::S_F_LOOP;
        end
      end
      bba_pkg::S_F_LOOP: begin
        if (!stat.i_lt_l) begin
          cmd.op    = bba_pkg::DP_F_OK;
          state_nxt = bba_pkg::S_DONE;
        end else begin
          cmd.op    = bba_pkg::DP_F_LOOP;
          state_nxt = bba_pkg::S_F_RD;
        end
      end
      bba_pkg::S_F_RD: state_nxt = bba_pkg::S_F_WR;
      bba_pkg::S_F_WR: begin
        cmd.op    = bba_pkg::DP_F_WR;
        state_nxt = stat.merge ? bba_pkg::S_F_LOOP : bba_pkg::S_F_END;
      end
      bba_pkg::S_F_END: begin
        cmd.op    = bba_pkg::DP_F_OK;
        state_nxt = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = bba_pkg::DP_PUSH;
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");
  a_push_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bba_pkg::DP_PUSH) |=> (state_r == bba_pkg::S_IDLE))
    else $error("controller not idle after result push");
`endif

endmodule

>>> src/bitmap_buddy_allocator.sv
`timescale 1ns / 1ps
// Buddy allocator over up to MAX_LEAVES blocks of MIN_BLOCK_BYTES (a power of two) bytes,
// one request at a time, one result per request. Free bits live in a 32-bit-wide bitmap RAM,
// level tags in a tag RAM. An allocate scans bitmap words level by level from the requested
// one upward and then splits the found block down (level 0 spans up to MAX_LEAVES/32 words);
// a free reads the block's level tag and merges with free buddies level by level; a request
// rejected on size or capacity goes straight to its result. A rebuild request, and the
// clearing pass after reset, sweep both RAMs over MAX_LEAVES entries (1024 by default) and
// then mark the odd last block of each level free; no request is taken during that pass,
// configuration writes are. The result register lets the next request in while a result
// waits to be taken.
module bitmap_buddy_allocator #(
  parameter int MAX_LEAVES      = bba_pkg::MAX_LEAVES_DEF,
  parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF,
  parameter int LEVEL_COUNT     = bba_pkg::LEVEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [47:0] in_request_size,
  input  logic [47:0] in_release_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [47:0] out_granted_address,
  output logic [3:0]  out_block_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [10:0]       leaf_count_r;
  logic [47:0]       pool_base_r;
  bba_pkg::dp_cmd_t  cmd;
  bba_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r <= 11'(bba_pkg::LEAF_COUNT_RESET);
      pool_base_r  <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        pool_base_r <= pwdata[47:0];
      end else begin
        leaf_count_r <= pwdata[10:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[3] ? {16'd0, pool_base_r} : {53'd0, leaf_count_r};

  bba_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_datapath #(
    .MAX_LEAVES      (MAX_LEAVES),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
    .LEVEL_COUNT     (LEVEL_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_kind             (in_kind),
    .in_request_size     (in_request_size),
    .in_release_address  (in_release_address),
    .leaf_count          (leaf_count_r),
    .pool_base           (pool_base_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_block_level     (out_block_level)
  );

endmodule
